FILE: design/lcg_keystream_xor_seekable_core_defines.svh
// Assertion macros shared by the keystream core modules.
`ifndef LCG_KEYSTREAM_XOR_SEEKABLE_CORE_DEFINES_SVH
`define LCG_KEYSTREAM_XOR_SEEKABLE_CORE_DEFINES_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define LCGK_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lcgk: invariant violated");
// Condition whose consequence must hold in the next cycle.
`define LCGK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcgk: next-cycle check failed");
`else
`define LCGK_ASSERT(label, prop)
`define LCGK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/lcgk_pkg.sv
// Types, codes and constants shared by the keystream core modules.
package lcgk_pkg;

  // Register reset values.
  localparam logic [31:0] LCGK_INIT_KEY_RST   = 32'd0;
  localparam logic [31:0] LCGK_MULTIPLIER_RST = 32'd214013;
  localparam logic [31:0] LCGK_INCREMENT_RST  = 32'd2531011;
  localparam logic [4:0]  LCGK_KEY_SHIFT_RST  = 5'd24;

  // Default depth of the command queue between front and back.
  localparam int LCGK_QUEUE_DEPTH = 4;

  // Function codes on the input channel.
  typedef enum logic [1:0] {
    FUNC_DATA     = 2'd0,
    FUNC_SEEK_ABS = 2'd1,
    FUNC_SEEK_REL = 2'd2
  } func_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_INITIAL_KEY = 2'd0,
    CFG_MULTIPLIER  = 2'd1,
    CFG_INCREMENT   = 2'd2,
    CFG_KEY_SHIFT   = 2'd3
  } cfg_reg_t;

  // Command kinds handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_NOP    = 2'd1,
    CMD_FWD    = 2'd2,
    CMD_RELOAD = 2'd3
  } cmd_kind_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ACC_A,
    BK_ACC_C,
    BK_STEP_C,
    BK_STEP_A,
    BK_FINAL
  } back_state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         data_in;
    logic [31:0]        target_offset;
    logic signed [31:0] delta_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       seek_error;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_beat_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        err;
    logic [31:0] arg;
  } cmd_t;

  // First sequencer step for a remaining advance count.
  function automatic back_state_t bk_first_step(logic [31:0] n);
    back_state_t s;
    if (n == 32'd0) begin
      s = BK_FINAL;
    end else if (n[0]) begin
      s = BK_ACC_A;
    end else begin
      s = BK_STEP_C;
    end
    return s;
  endfunction

endpackage

FILE: design/lcgk_front.sv
// Front end: accepts input beats, tracks the byte position and classifies seeks.
module lcgk_front import lcgk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_beat_t cfg_wr,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  input  logic      q_full,
  output logic      q_push,
  output cmd_t      q_cmd
);

  logic [31:0] pos_r, pos_nxt;
  logic [33:0] rel_sum;
  logic [31:0] seek_tgt;
  logic [31:0] seek_dist;
  logic        seek_gt, seek_lt;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Relative target in a signed 34-bit range, then the common seek compare.
  assign rel_sum   = {2'b00, pos_r} + {{2{in_item.delta_offset[31]}}, in_item.delta_offset};
  assign seek_tgt  = (in_item.func == FUNC_SEEK_ABS) ? in_item.target_offset : rel_sum[31:0];
  assign seek_gt   = seek_tgt > pos_r;
  assign seek_lt   = seek_tgt < pos_r;
  assign seek_dist = seek_tgt - pos_r;

  // Classify the beat into a back-end command and the next position.
  always_comb begin
    q_cmd      = '0;
    q_cmd.kind = CMD_NOP;
    q_cmd.data = in_item.data_in;
    pos_nxt    = pos_r;
    case (in_item.func)
      FUNC_DATA: begin
        q_cmd.kind = CMD_DATA;
        pos_nxt    = pos_r + 32'd1;
      end
      FUNC_SEEK_ABS, FUNC_SEEK_REL: begin
        if (in_item.func == FUNC_SEEK_REL && in_item.delta_offset == 32'sd0) begin
          q_cmd.kind = CMD_NOP;
        end else if (in_item.func == FUNC_SEEK_REL && rel_sum[33]) begin
          q_cmd.kind = CMD_NOP;
          q_cmd.err  = 1'b1;
        end else if (seek_gt) begin
          q_cmd.kind = CMD_FWD;
          q_cmd.arg  = seek_dist;
          pos_nxt    = seek_tgt;
        end else if (seek_lt) begin
          q_cmd.kind = CMD_RELOAD;
          q_cmd.arg  = seek_tgt;
          pos_nxt    = seek_tgt;
        end else begin
          q_cmd.kind = CMD_NOP;
        end
      end
      default: begin
        q_cmd.kind = CMD_NOP;
      end
    endcase
  end

  // Position register; a new seed restarts the stream at zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 32'd0;
    end else if (cfg_wr.valid && cfg_wr.index == CFG_INITIAL_KEY) begin
      pos_r <= 32'd0;
    end else if (q_push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: design/lcgk_queue.sv
// Command queue between the front end and the back end.
`include "lcg_keystream_xor_seekable_core_defines.svh"
module lcgk_queue import lcgk_pkg::*; #(
  parameter int DEPTH = LCGK_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output logic rd_valid,
  output cmd_t rd_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = count_r == CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  // Storage is written at the tail.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `LCGK_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH))
  `LCGK_ASSERT(a_no_push_full, !(push && full))
  `LCGK_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_r == $past(count_r) + CNT_W'(1))

endmodule

FILE: design/lcgk_back.sv
// Back end: keystream XOR for data and a shared-multiplier sequencer for seeks.
`include "lcg_keystream_xor_seekable_core_defines.svh"
module lcgk_back import lcgk_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_beat_t cfg_wr,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  back_state_t state_r, state_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] init_key_r, init_key_nxt;
  logic [31:0] mul_r, mul_nxt;
  logic [31:0] inc_r, inc_nxt;
  logic [4:0]  shift_r, shift_nxt;
  logic [31:0] acc_a_r, acc_a_nxt;
  logic [31:0] acc_c_r, acc_c_nxt;
  logic [31:0] sa_r, sa_nxt;
  logic [31:0] sc_r, sc_nxt;
  logic [31:0] n_r, n_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  logic [31:0] mul_a, mul_b, add_c, prod, mac;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The one multiply-add unit, shared by all steps.
  assign prod = mul_a * mul_b;
  assign mac  = prod + add_c;

  // Sequencer: one multiply-add per cycle over the bits of the advance count.
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    init_key_nxt  = init_key_r;
    mul_nxt       = mul_r;
    inc_nxt       = inc_r;
    shift_nxt     = shift_r;
    acc_a_nxt     = acc_a_r;
    acc_c_nxt     = acc_c_r;
    sa_nxt        = sa_r;
    sc_nxt        = sc_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    mul_a         = mul_r;
    mul_b         = key_r;
    add_c         = inc_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      BK_IDLE: begin
        if (q_valid && (!out_valid_r || out_ready)) begin
          q_pop         = 1'b1;
          out_valid_nxt = 1'b1;
          out_item_nxt  = '0;
          case (q_cmd.kind)
            CMD_DATA: begin
              out_item_nxt.data_out = q_cmd.data ^ 8'(key_r >> shift_r);
              key_nxt               = mac;
            end
            CMD_FWD, CMD_RELOAD: begin
              acc_a_nxt = 32'd1;
              acc_c_nxt = 32'd0;
              sa_nxt    = mul_r;
              sc_nxt    = inc_r;
              n_nxt     = q_cmd.arg;
              state_nxt = bk_first_step(q_cmd.arg);
              if (q_cmd.kind == CMD_RELOAD) begin
                key_nxt = init_key_r;
              end
            end
            default: begin
              out_item_nxt.seek_error = q_cmd.err;
            end
          endcase
        end
      end
      BK_ACC_A: begin
        mul_a     = sa_r;
        mul_b     = acc_a_r;
        add_c     = 32'd0;
        acc_a_nxt = mac;
        state_nxt = BK_ACC_C;
      end
      BK_ACC_C: begin
        mul_a     = sa_r;
        mul_b     = acc_c_r;
        add_c     = sc_r;
        acc_c_nxt = mac;
        state_nxt = (n_r[31:1] == 31'd0) ? BK_FINAL : BK_STEP_C;
      end
      BK_STEP_C: begin
        mul_a     = sa_r;
        mul_b     = sc_r;
        add_c     = sc_r;
        sc_nxt    = mac;
        state_nxt = BK_STEP_A;
      end
      BK_STEP_A: begin
        mul_a     = sa_r;
        mul_b     = sa_r;
        add_c     = 32'd0;
        sa_nxt    = mac;
        n_nxt     = {1'b0, n_r[31:1]};
        state_nxt = bk_first_step({1'b0, n_r[31:1]});
      end
      BK_FINAL: begin
        mul_a     = acc_a_r;
        mul_b     = key_r;
        add_c     = acc_c_r;
        key_nxt   = mac;
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // Register writes must arrive only while the block is idle; not enforced.
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_INITIAL_KEY: begin
          init_key_nxt = cfg_wr.data;
          key_nxt      = cfg_wr.data;
        end
        CFG_MULTIPLIER: mul_nxt   = cfg_wr.data;
        CFG_INCREMENT:  inc_nxt   = cfg_wr.data;
        CFG_KEY_SHIFT:  shift_nxt = cfg_wr.data[4:0];
        default: begin
          shift_nxt = shift_r;
        end
      endcase
    end
  end

  // Control state and registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      key_r       <= LCGK_INIT_KEY_RST;
      init_key_r  <= LCGK_INIT_KEY_RST;
      mul_r       <= LCGK_MULTIPLIER_RST;
      inc_r       <= LCGK_INCREMENT_RST;
      shift_r     <= LCGK_KEY_SHIFT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      init_key_r  <= init_key_nxt;
      mul_r       <= mul_nxt;
      inc_r       <= inc_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers of the advance and the result payload.
  always_ff @(posedge clk) begin
    acc_a_r    <= acc_a_nxt;
    acc_c_r    <= acc_c_nxt;
    sa_r       <= sa_nxt;
    sc_r       <= sc_nxt;
    n_r        <= n_nxt;
    out_item_r <= out_item_nxt;
  end

  `LCGK_ASSERT(a_pop_only_idle, !(q_pop && state_r != BK_IDLE))
  `LCGK_ASSERT_NEXT(a_pop_gives_result, q_pop, out_valid_r)
  `LCGK_ASSERT_NEXT(a_final_to_idle, state_r == BK_FINAL, state_r == BK_IDLE)

endmodule

FILE: design/lcg_keystream_xor_seekable_core.sv
// Data bytes: the input beat passes the command queue, then the output register,
// before its result beat; one byte per cycle sustained while out_ready holds high.
// Seeks: same result path; the back end then runs ACC_A/ACC_C per set bit and
// STEP_C/STEP_A between bits of the advance count, then BK_FINAL, on its single
// 32x32 multiply-add unit, and later items wait in the command queue meanwhile.
// Reset (synchronous, active low) loads register defaults, key 0 and position 0.
module lcg_keystream_xor_seekable_core import lcgk_pkg::*; #(
  parameter int QUEUE_DEPTH = LCGK_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_beat_t cfg_wr;
  logic      q_push, q_full, q_pop, q_valid;
  cmd_t      q_wr_cmd, q_rd_cmd;

  // Register writes are always taken.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  lcgk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_wr_cmd)
  );

  lcgk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_cmd   (q_wr_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd_cmd)
  );

  lcgk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .q_valid   (q_valid),
    .q_cmd     (q_rd_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
